// ----- rtl/psp_pkg.sv -----
// ----------------------------------------------------------------------------
// psp_pkg
// Types, codes and default sizes shared by the segment packer modules.
// ----------------------------------------------------------------------------
package psp_pkg;

	localparam int NUM_DEST_DEF    = 16;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int NUM_FLOWS_DEF   = 256;
	localparam int MAX_SEGS_DEF    = 64;

	localparam logic [15:0] MSS_RESET = 16'd1460;

	localparam logic [1:0] ST_SEG   = 2'd0;
	localparam logic [1:0] ST_OK    = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic FUNC_ENQ   = 1'b0;
	localparam logic FUNC_BUILD = 1'b1;

	localparam logic [2:0] ADDR_MSS = 3'd0;

	typedef struct packed {
		logic        func;
		logic [3:0]  dest;
		logic [7:0]  flow_id;
		logic [31:0] byte_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  seg_flow;
		logic [31:0] seg_seq;
		logic [15:0] seg_bytes;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  flow;
		logic [31:0] remaining;
	} entry_t;

	typedef enum logic [1:0] {
		PS_IDLE,
		PS_ENT,
		PS_SEQ,
		PS_CALC
	} pack_state_t;

	typedef struct packed {
		logic ent_rd;
		logic seq_rd;
		logic emit_ok;
	} pack_ctl_t;

endpackage

// ----- rtl/psp_entry_mem.sv -----
// ----------------------------------------------------------------------------
// psp_entry_mem
// Queue entry store: one flow and remaining byte count per slot, registered read.
// ----------------------------------------------------------------------------
module psp_entry_mem #(
	parameter int DEPTH = psp_pkg::NUM_DEST_DEF * psp_pkg::QUEUE_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output psp_pkg::entry_t  rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  psp_pkg::entry_t  wr_data
);

	psp_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/psp_seq_mem.sv -----
// ----------------------------------------------------------------------------
// psp_seq_mem
// Next sequence number per flow, registered read.
// ----------------------------------------------------------------------------
module psp_seq_mem #(
	parameter int NUM_FLOWS = psp_pkg::NUM_FLOWS_DEF,
	parameter int FW        = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [FW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic          wr_en,
	input  logic [FW-1:0] wr_addr,
	input  logic [31:0]   wr_data
);

	logic [31:0] mem [NUM_FLOWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/per_destination_segment_packer.sv -----
// ----------------------------------------------------------------------------
// per_destination_segment_packer
// Per-destination FIFOs of flow data, drained into packets of up to mss bytes.
// ----------------------------------------------------------------------------
// An enqueue item gives one status item. A build item gives its segment
// items one at a time, each through entry read, sequence read, and update
// and write-back, in turn through the entry store and the sequence store;
// the update step waits while the output is stalled, and the input stays
// stalled until the build ends. An empty build gives one status item. After
// reset the block clears the sequence store, one flow per cycle, before it
// accepts its first item; configuration writes are taken at any time.
module per_destination_segment_packer #(
	parameter int NUM_DEST    = psp_pkg::NUM_DEST_DEF,
	parameter int QUEUE_DEPTH = psp_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_FLOWS   = psp_pkg::NUM_FLOWS_DEF,
	parameter int MAX_SEGS    = psp_pkg::MAX_SEGS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  psp_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output psp_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int DW   = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;
	localparam int DXW  = (DW > 4) ? DW : 4;
	localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int EDEP = NUM_DEST * QUEUE_DEPTH;
	localparam int AW   = (EDEP > 1) ? $clog2(EDEP) : 1;
	localparam int FW   = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
	localparam int FXW  = (FW > 8) ? FW : 8;
	localparam int SW   = $clog2(MAX_SEGS + 1);
	localparam int CLW  = $clog2(NUM_FLOWS + 1);

	// configuration
	logic [15:0] mss_q;

	assign pready = 1'b1;
	assign prdata = (paddr == psp_pkg::ADDR_MSS) ? {16'd0, mss_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_q <= psp_pkg::MSS_RESET;
		end else if (psel && penable && pwrite && paddr == psp_pkg::ADDR_MSS) begin
			mss_q <= pwdata[15:0];
		end
	end

	// per-destination queue pointers
	logic [QW-1:0] head_q [NUM_DEST];
	logic [CW-1:0] cnt_q  [NUM_DEST];

	psp_pkg::pack_state_t state_q, state_nx;
	psp_pkg::pack_ctl_t   ctl;

	logic [DW-1:0]  dest_q;
	logic [15:0]    cum_q;
	logic [SW-1:0]  nseg_q;
	logic [CLW-1:0] clr_q;
	logic           clearing;

	psp_pkg::out_item_t out_q;
	logic               out_vld_q;
	logic               out_free;

	assign clearing  = clr_q != CLW'(NUM_FLOWS);
	assign out_free  = !out_vld_q || !out_stall;
	assign in_stall  = clearing || state_q != psp_pkg::PS_IDLE || !out_free;
	assign out_valid = out_vld_q;
	assign out_item  = out_q;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// input decode
	logic [DXW-1:0] in_dext;
	logic [DW-1:0]  in_didx;
	logic           dest_bad;
	logic [QW-1:0]  in_head;
	logic [CW-1:0]  in_cnt;
	logic           enq_full;
	logic [CW:0]    slot_sum;
	logic [QW-1:0]  enq_slot;
	logic           build_empty;
	logic [1:0]     in_status;

	assign in_dext  = DXW'(in_item.dest);
	assign in_didx  = in_dext[DW-1:0];
	assign dest_bad = 32'(in_item.dest) >= 32'(NUM_DEST);
	assign in_head  = dest_bad ? '0 : head_q[in_didx];
	assign in_cnt   = dest_bad ? '0 : cnt_q[in_didx];
	assign enq_full = dest_bad || 32'(in_item.flow_id) >= 32'(NUM_FLOWS)
		|| 32'(in_cnt) >= 32'(QUEUE_DEPTH);
	assign slot_sum = (CW+1)'(in_head) + (CW+1)'(in_cnt);
	assign enq_slot = (32'(slot_sum) >= 32'(QUEUE_DEPTH))
		? QW'(32'(slot_sum) - 32'(QUEUE_DEPTH)) : QW'(slot_sum);
	assign build_empty = dest_bad || in_cnt == '0 || mss_q == 16'd0;
	assign in_status = (in_item.func == psp_pkg::FUNC_ENQ)
		? (enq_full ? psp_pkg::ST_FULL : psp_pkg::ST_OK) : psp_pkg::ST_EMPTY;

	// entry store ports
	logic            ent_rd, ent_wr;
	logic [AW-1:0]   ent_raddr, ent_waddr;
	psp_pkg::entry_t ent_rdata, ent_wdata;

	// segment computation in the update stage
	logic [31:0]   seq_rdata;
	logic [15:0]   space;
	logic          split;
	logic [15:0]   take;
	logic [15:0]   cum_nx;
	logic [CW-1:0] cnt_nx;
	logic [QW-1:0] head_nx;
	logic          seg_done;
	logic [FXW-1:0] fl_ext;
	logic [FW-1:0]  fl_idx;

	assign space    = mss_q - cum_q;
	assign split    = ent_rdata.remaining > 32'(space);
	assign take     = split ? space : ent_rdata.remaining[15:0];
	assign cum_nx   = cum_q + take;
	assign cnt_nx   = cnt_q[dest_q] - CW'(1);
	assign head_nx  = (32'(head_q[dest_q]) + 32'd1 >= 32'(QUEUE_DEPTH))
		? '0 : head_q[dest_q] + QW'(1);
	assign seg_done = split || cnt_nx == '0 || cum_nx == mss_q
		|| 32'(nseg_q) + 32'd1 >= 32'(MAX_SEGS);
	assign fl_ext   = FXW'(ent_rdata.flow);
	assign fl_idx   = fl_ext[FW-1:0];

	assign ent_rd    = ctl.ent_rd;
	assign ent_raddr = AW'(32'(dest_q) * 32'(QUEUE_DEPTH) + 32'(head_q[dest_q]));
	assign ent_wr    = (in_acc && in_item.func == psp_pkg::FUNC_ENQ && !enq_full
		&& in_item.byte_count != 32'd0) || (ctl.emit_ok && split);
	assign ent_waddr = (state_q == psp_pkg::PS_CALC) ? ent_raddr
		: AW'(32'(in_didx) * 32'(QUEUE_DEPTH) + 32'(enq_slot));
	assign ent_wdata = (state_q == psp_pkg::PS_CALC)
		? '{flow: ent_rdata.flow, remaining: ent_rdata.remaining - 32'(space)}
		: '{flow: in_item.flow_id, remaining: in_item.byte_count};

	psp_entry_mem #(.DEPTH(EDEP), .AW(AW)) u_entry (
		.clk     (clk),
		.rd_en   (ent_rd),
		.rd_addr (ent_raddr),
		.rd_data (ent_rdata),
		.wr_en   (ent_wr),
		.wr_addr (ent_waddr),
		.wr_data (ent_wdata)
	);

	// sequence store, cleared after reset
	logic          seq_wr;
	logic [FW-1:0] seq_waddr;
	logic [31:0]   seq_wdata;

	assign seq_wr    = clearing || ctl.emit_ok;
	assign seq_waddr = clearing ? clr_q[FW-1:0] : fl_idx;
	assign seq_wdata = clearing ? 32'd0 : seq_rdata + 32'(take);

	psp_seq_mem #(.NUM_FLOWS(NUM_FLOWS), .FW(FW)) u_seq (
		.clk     (clk),
		.rd_en   (ctl.seq_rd),
		.rd_addr (fl_idx),
		.rd_data (seq_rdata),
		.wr_en   (seq_wr),
		.wr_addr (seq_waddr),
		.wr_data (seq_wdata)
	);

	// sequencer
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			psp_pkg::PS_IDLE: begin
				if (in_acc && in_item.func == psp_pkg::FUNC_BUILD && !build_empty) begin
					state_nx = psp_pkg::PS_ENT;
				end
			end
			psp_pkg::PS_ENT:  state_nx = psp_pkg::PS_SEQ;
			psp_pkg::PS_SEQ:  state_nx = psp_pkg::PS_CALC;
			psp_pkg::PS_CALC: begin
				if (out_free) begin
					state_nx = seg_done ? psp_pkg::PS_IDLE : psp_pkg::PS_ENT;
				end
			end
			default: state_nx = psp_pkg::PS_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			psp_pkg::PS_ENT:  ctl.ent_rd  = 1'b1;
			psp_pkg::PS_SEQ:  ctl.seq_rd  = 1'b1;
			psp_pkg::PS_CALC: ctl.emit_ok = out_free;
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psp_pkg::PS_IDLE;
			clr_q   <= '0;
			dest_q  <= '0;
			cum_q   <= '0;
			nseg_q  <= '0;
			for (int i = 0; i < NUM_DEST; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			state_q <= state_nx;
			if (clearing) begin
				clr_q <= clr_q + CLW'(1);
			end
			if (in_acc) begin
				dest_q <= in_didx;
				cum_q  <= '0;
				nseg_q <= '0;
				if (in_item.func == psp_pkg::FUNC_ENQ && !enq_full
					&& in_item.byte_count != 32'd0) begin
					cnt_q[in_didx] <= in_cnt + CW'(1);
				end
			end
			if (ctl.emit_ok) begin
				cum_q  <= cum_nx;
				nseg_q <= nseg_q + SW'(1);
				if (!split) begin
					head_q[dest_q] <= head_nx;
					cnt_q[dest_q]  <= cnt_nx;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (in_acc && (in_item.func == psp_pkg::FUNC_ENQ || build_empty)) begin
			out_vld_q <= 1'b1;
		end else if (ctl.emit_ok) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_q <= '{status: in_status, seg_flow: 8'd0, seg_seq: 32'd0,
				seg_bytes: 16'd0, last: 1'b1};
		end else if (ctl.emit_ok) begin
			out_q <= '{status: psp_pkg::ST_SEG, seg_flow: ent_rdata.flow,
				seg_seq: seq_rdata, seg_bytes: take, last: seg_done};
		end
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != psp_pkg::PS_IDLE |-> in_stall)
		else $error("input accepted during a build");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_ok |-> !(out_vld_q && out_stall))
		else $error("segment emitted over a waiting item");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != psp_pkg::PS_IDLE |-> 32'(cnt_q[dest_q]) <= 32'(QUEUE_DEPTH)
			&& cnt_q[dest_q] != '0)
		else $error("build on an empty or overfull queue");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_acc && state_q == psp_pkg::PS_IDLE)
		else $error("activity during sequence store clear");

endmodule
